// ===== hw/rtl/stt_pkg.sv =====
package stt_pkg;

  // Fixed field widths of the ports
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned TOKEN_W    = 64;
  localparam int unsigned TIME_IN_W  = 48;
  localparam int unsigned CFG_W      = 48;
  localparam int unsigned SLOT_OUT_W = 2;
  localparam int unsigned IN_DATA_W  = TOKEN_W + TIME_IN_W;
  localparam int unsigned OUT_DATA_W = 8;

  // Session lifetime after reset: one day in microseconds
  localparam logic [CFG_W-1:0] USEC_PER_SEC = CFG_W'(1000000);
  localparam logic [CFG_W-1:0] EXPIRY_RESET = CFG_W'(86400) * USEC_PER_SEC;

  // Request kinds
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT     = 2'd0,
    REQ_VALIDATE   = 2'd1,
    REQ_INVALIDATE = 2'd2
  } req_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } st_e;

endpackage

// ===== hw/rtl/stt_ram.sv =====
module stt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/stt_age_cmp.sv =====
module stt_age_cmp import stt_pkg::*; #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                 age_mode_i,  // 1: age > expiry, 0: oldest > created
  input  logic [TIME_BITS-1:0] now_i,
  input  logic [TIME_BITS-1:0] created_i,
  input  logic [TIME_BITS-1:0] oldest_i,
  input  logic [CFG_W-1:0]     expiry_i,
  output logic                 gt_o
);

  localparam int unsigned CW = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

  logic [TIME_BITS-1:0] age;
  logic [CW-1:0]        op_a;
  logic [CW-1:0]        op_b;

  // Age wraps modulo the time width
  assign age = now_i - created_i;

  // Single shared magnitude compare
  assign op_a = age_mode_i ? CW'(age)      : CW'(oldest_i);
  assign op_b = age_mode_i ? CW'(expiry_i) : CW'(created_i);
  assign gt_o = op_a > op_b;

endmodule

// ===== hw/rtl/session_token_table.sv =====
// Channel   Dir  Handshake             Payload
// s_axis    in   tvalid/tready         tuser: req_type; tdata: token, now_time
// m_axis    out  tvalid/tready         tdata: matched, slot, evicted
// cfg       in   cfg_we_i (no stall)   cfg_wdata_i: expiry_time
//
// Insert and validate scan one slot per cycle through the registered read of
// the token and time memories, to the end or stopping early. Invalidate,
// unused kinds and zero token validates skip the scan. The scan length is set
// by the single compare unit and memory read port. Reset clears the active
// bits and the sequencer; slot memories need no clearing. A stalled result
// holds the sequencer in its final state until the output register frees up.
module session_token_table import stt_pkg::*; #(
  parameter int unsigned SLOTS      = 4,
  parameter int unsigned TOKEN_BITS = 64,
  parameter int unsigned TIME_BITS  = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,  // [63:0] token, [111:64] now_time
  input  logic [REQ_W-1:0]      s_axis_tuser_i,  // [1:0] req_type
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,  // [0] matched, [2:1] slot, [3] evicted
  input  logic                  cfg_we_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i
);

  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned IW = $clog2(SLOTS + 1);

  st_e                   state_q, state_d;
  req_e                  req_q;
  req_e                  in_req;
  logic [TOKEN_BITS-1:0] tok_q, in_tok;
  logic [TIME_BITS-1:0]  now_q, oldest_q, oldest_nx;
  logic [CFG_W-1:0]      expiry_q;
  logic [IW-1:0]         idx_q;
  logic                  rd_vld_q;
  logic [AW-1:0]         rd_idx_q;
  logic [AW-1:0]         pick_q, pick_nx;
  logic [SLOTS-1:0]      active_q;
  logic                  res_matched_q, res_evicted_q;
  logic [AW-1:0]         res_slot_q;
  logic                  out_vld_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  logic                  in_acc, out_free;
  logic                  issue, finish, fin_matched, fin_evicted, clr_one, ram_we;
  logic                  last, cmp_gt;
  logic [TOKEN_BITS-1:0] rd_token;
  logic [TIME_BITS-1:0]  rd_created;

  assign in_req   = req_e'(s_axis_tuser_i);
  assign in_tok   = TOKEN_BITS'(s_axis_tdata_i[TOKEN_W-1:0]);
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_vld_q || m_axis_tready_i;
  assign last     = rd_idx_q == AW'(SLOTS - 1);

  // Slot storage
  stt_ram #(.WIDTH(TOKEN_BITS), .DEPTH(SLOTS)) u_tok_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pick_nx),
    .wdata_i (tok_q),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rd_token)
  );

  stt_ram #(.WIDTH(TIME_BITS), .DEPTH(SLOTS)) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pick_nx),
    .wdata_i (now_q),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rd_created)
  );

  // Shared compare: expiry check on validate, oldest search on insert
  stt_age_cmp #(.TIME_BITS(TIME_BITS)) u_cmp (
    .age_mode_i (req_q == REQ_VALIDATE),
    .now_i      (now_q),
    .created_i  (rd_created),
    .oldest_i   (oldest_q),
    .expiry_i   (expiry_q),
    .gt_o       (cmp_gt)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_req == REQ_INSERT ||
              (in_req == REQ_VALIDATE && in_tok != '0)) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (finish) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Scan evaluation of the slot read in the previous cycle
  always_comb begin
    issue       = 1'b0;
    finish      = 1'b0;
    fin_matched = 1'b0;
    fin_evicted = 1'b0;
    clr_one     = 1'b0;
    ram_we      = 1'b0;
    pick_nx     = pick_q;
    oldest_nx   = oldest_q;
    if (state_q == ST_SCAN) begin
      issue = idx_q < IW'(SLOTS);
      if (rd_vld_q) begin
        if (req_q == REQ_INSERT) begin
          if (!active_q[rd_idx_q]) begin
            pick_nx     = rd_idx_q;
            finish      = 1'b1;
            fin_matched = 1'b1;
          end else begin
            if (rd_idx_q == '0 || cmp_gt) begin
              oldest_nx = rd_created;
              pick_nx   = rd_idx_q;
            end
            if (last) begin
              finish      = 1'b1;
              fin_matched = 1'b1;
              fin_evicted = 1'b1;
            end
          end
          ram_we = finish;
        end else begin
          if (active_q[rd_idx_q]) begin
            if (cmp_gt) begin
              clr_one = 1'b1;
            end else if (rd_token == tok_q) begin
              finish      = 1'b1;
              fin_matched = 1'b1;
              pick_nx     = rd_idx_q;
            end
          end
          if (last) finish = 1'b1;
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      rd_vld_q  <= 1'b0;
      active_q  <= '0;
      out_vld_q <= 1'b0;
      expiry_q  <= EXPIRY_RESET;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) expiry_q <= cfg_wdata_i;
      if (in_acc) begin
        idx_q    <= '0;
        rd_vld_q <= 1'b0;
        if (in_req == REQ_INVALIDATE) active_q <= '0;
      end else if (state_q == ST_SCAN) begin
        idx_q    <= idx_q + IW'(issue);
        rd_vld_q <= issue && !finish;
        if (clr_one) active_q[rd_idx_q] <= 1'b0;
        if (ram_we)  active_q[pick_nx]  <= 1'b1;
      end
      if (state_q == ST_DONE && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q         <= in_req;
      tok_q         <= in_tok;
      now_q         <= TIME_BITS'(s_axis_tdata_i[IN_DATA_W-1:TOKEN_W]);
      res_matched_q <= 1'b0;
      res_evicted_q <= 1'b0;
      res_slot_q    <= '0;
    end
    if (state_q == ST_SCAN) begin
      rd_idx_q <= idx_q[AW-1:0];
      pick_q   <= pick_nx;
      oldest_q <= oldest_nx;
      if (finish) begin
        res_matched_q <= fin_matched;
        res_evicted_q <= fin_evicted;
        res_slot_q    <= fin_matched ? pick_nx : '0;
      end
    end
    if (state_q == ST_DONE && out_free) begin
      out_data_q <= OUT_DATA_W'({res_evicted_q, SLOT_OUT_W'(res_slot_q), res_matched_q});
    end
  end

  assign s_axis_tready_o = state_q == ST_IDLE;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

  // Memory writes only at the end of an insert scan
  a_we_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == ST_SCAN && req_q == REQ_INSERT)
    else $error("slot write outside insert scan");

  // A written slot is active afterward
  a_we_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> active_q[$past(pick_nx)])
    else $error("inserted slot not active");

  // Read pipeline only alive during a scan
  a_rd_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> state_q == ST_SCAN)
    else $error("read pending outside scan");

  // An eviction is always reported as a successful insert
  a_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_data_q[3] |-> out_data_q[0])
    else $error("eviction without match flag");

endmodule
